// ----- hdl/psl_pkg.sv -----
// shared types and constants for the patch stack pixel lookup
`default_nettype none

package psl_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned MEM_ADDR_W = 12;
  localparam int unsigned RGB_W      = 3 * CHAN_W;
  localparam int unsigned RGBA_W     = 4 * CHAN_W;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_CNT_W = 4;

  localparam logic [CHAN_W-1:0] ALPHA_FULL = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_PUSH  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] w;
  } rect_sel_t;

  typedef struct packed {
    logic              status;
    logic              from_patch;
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/psl_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module psl_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/psl_rect_stack.sv -----
// rectangle stack with parallel hit test and newest-first selection
`default_nettype none

module psl_rect_stack #(
  parameter int unsigned MAX_PATCHES = 8,
  parameter int unsigned ADDR_W      = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_i,
  input  wire psl_pkg::func_e                 func_i,
  input  wire logic [psl_pkg::COORD_W-1:0]    px_i,
  input  wire logic [psl_pkg::COORD_W-1:0]    py_i,
  input  wire logic [psl_pkg::COORD_W-1:0]    w_i,
  input  wire logic [psl_pkg::COORD_W-1:0]    h_i,
  input  wire logic [ADDR_W-1:0]              base_i,
  output      logic                           full_o,
  output      psl_pkg::rect_sel_t             sel_o,
  output      logic [ADDR_W-1:0]              base_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PATCHES + 1);
  localparam int unsigned IDX_W = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;

  logic [CNT_W-1:0]              cnt_q;
  logic [psl_pkg::COORD_W-1:0]   ox_q [MAX_PATCHES];
  logic [psl_pkg::COORD_W-1:0]   oy_q [MAX_PATCHES];
  logic [psl_pkg::COORD_W-1:0]   w_q  [MAX_PATCHES];
  logic [psl_pkg::COORD_W-1:0]   h_q  [MAX_PATCHES];
  logic [ADDR_W-1:0]             base_q [MAX_PATCHES];

  logic [psl_pkg::COORD_W-1:0]   lane_dx [MAX_PATCHES];
  logic [psl_pkg::COORD_W-1:0]   lane_dy [MAX_PATCHES];
  logic [MAX_PATCHES-1:0]        hit_d;
  logic [MAX_PATCHES-1:0]        hit_q;
  logic [psl_pkg::COORD_W-1:0]   px_q;
  logic [psl_pkg::COORD_W-1:0]   py_q;
  logic [IDX_W-1:0]              sel_idx;
  psl_pkg::rect_sel_t            sel_d;
  logic                          push_ok;

  assign full_o  = (cnt_q == CNT_W'(MAX_PATCHES));
  assign push_ok = req_i && (func_i == psl_pkg::FUNC_PUSH) && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if (req_i && (func_i == psl_pkg::FUNC_CLEAR)) begin
        cnt_q <= '0;
      end else if (push_ok) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PATCHES; i++) begin
      if (push_ok && (cnt_q == CNT_W'(i))) begin
        ox_q[i]   <= px_i;
        oy_q[i]   <= py_i;
        w_q[i]    <= w_i;
        h_q[i]    <= h_i;
        base_q[i] <= base_i;
      end
    end
  end

  // per-lane containment test, only live lanes count
  always_comb begin
    for (int i = 0; i < MAX_PATCHES; i++) begin
      lane_dx[i] = px_i - ox_q[i];
      lane_dy[i] = py_i - oy_q[i];
      hit_d[i]   = (CNT_W'(i) < cnt_q) && (px_i >= ox_q[i]) && (py_i >= oy_q[i])
                   && (lane_dx[i] < w_q[i]) && (lane_dy[i] < h_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      hit_q <= hit_d;
      px_q  <= px_i;
      py_q  <= py_i;
    end
  end

  // newest lane wins
  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < MAX_PATCHES; i++) begin
      if (hit_q[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
    sel_d.hit = |hit_q;
    sel_d.dx  = px_q - ox_q[sel_idx];
    sel_d.dy  = py_q - oy_q[sel_idx];
    sel_d.w   = w_q[sel_idx];
  end

  always_ff @(posedge clk_i) begin
    sel_o  <= sel_d;
    base_o <= base_q[sel_idx];
  end

endmodule

`default_nettype wire

// ----- hdl/psl_fifo.sv -----
// small result queue in flip-flops
`default_nettype none

module psl_fifo #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/patch_stack_pixel_lookup.sv -----
// top level of the patch stack pixel lookup
//
// requests enter on the s_axis group: tuser carries the function (clear stack,
// push rectangle, write patch pixel, query pixel), tdata the coordinates,
// rectangle size, memory address and the red, green, blue and alpha words.
// every request yields exactly one result on the m_axis group, in order.
// a request is taken in any cycle while fewer than eight requests are
// outstanding, so the block sustains one request per cycle.
// a result is offered once its request has passed the stages: hit test,
// newest-rectangle select, row offset multiply, patch memory access and
// result capture into an eight-entry output queue.
// PATCH_PIXELS must be a power of two; memory addresses wrap at that size.
// a stalled receiver fills the output queue and tready falls once eight
// requests are outstanding; nothing is dropped.
// reset empties the rectangle stack, the pipeline and the queue; the patch
// memory keeps its contents and is undefined until written.
`default_nettype none

module patch_stack_pixel_lookup #(
  parameter int unsigned MAX_PATCHES  = 8,
  parameter int unsigned PATCH_PIXELS = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // pixel_x, pixel_y, rect_width, rect_height, mem_addr, red, green, blue, alpha, pad
  input  wire logic [143:0] s_axis_tdata,
  // func
  input  wire logic [1:0]   s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output      logic [63:0]  m_axis_tdata,
  // from_patch, status
  output      logic [1:0]   m_axis_tuser
);

  localparam int unsigned ADDR_W = $clog2(PATCH_PIXELS);
  localparam int unsigned RES_W  = $bits(psl_pkg::result_t);

  logic                              accept;
  psl_pkg::func_e                    in_func;
  logic [ADDR_W-1:0]                 in_addr;
  logic                              stack_full;
  psl_pkg::rect_sel_t                sel;
  logic [ADDR_W-1:0]                 sel_base;

  logic                              v1_q, v2_q, v3_q, v4_q;
  psl_pkg::func_e                    func1_q, func2_q, func3_q, func4_q;
  logic [psl_pkg::RGBA_W-1:0]        rgba1_q, rgba2_q, rgba3_q, rgba4_q;
  logic [ADDR_W-1:0]                 waddr1_q, waddr2_q, waddr3_q;
  logic                              status1_q, status2_q, status3_q, status4_q;
  logic                              hit3_q, hit4_q;
  logic [2*psl_pkg::COORD_W-1:0]     prod_d;
  logic [ADDR_W-1:0]                 prod3_q;
  logic [ADDR_W-1:0]                 off3_q;

  logic                              ram_we;
  logic                              ram_re;
  logic [ADDR_W-1:0]                 ram_addr;
  logic [psl_pkg::RGB_W-1:0]         ram_rdata;

  psl_pkg::result_t                  res_d;
  psl_pkg::result_t                  res_out;
  logic [RES_W-1:0]                  fifo_data;
  logic [psl_pkg::FIFO_CNT_W-1:0]    inflight_q;
  logic                              pop;

  assign s_axis_tready = (inflight_q < psl_pkg::FIFO_CNT_W'(psl_pkg::FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign in_func       = psl_pkg::func_e'(s_axis_tuser);
  assign in_addr       = ADDR_W'(s_axis_tdata[75:64]);

  psl_rect_stack #(
    .MAX_PATCHES (MAX_PATCHES),
    .ADDR_W      (ADDR_W)
  ) u_rect_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (accept),
    .func_i (in_func),
    .px_i   (s_axis_tdata[15:0]),
    .py_i   (s_axis_tdata[31:16]),
    .w_i    (s_axis_tdata[47:32]),
    .h_i    (s_axis_tdata[63:48]),
    .base_i (in_addr),
    .full_o (stack_full),
    .sel_o  (sel),
    .base_o (sel_base)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      inflight_q <= '0;
    end else begin
      v1_q       <= accept;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      inflight_q <= inflight_q + psl_pkg::FIFO_CNT_W'(accept)
                    - psl_pkg::FIFO_CNT_W'(pop);
    end
  end

  assign prod_d = sel.dy * sel.w;

  always_ff @(posedge clk_i) begin
    func1_q   <= in_func;
    rgba1_q   <= s_axis_tdata[139:76];
    waddr1_q  <= in_addr;
    status1_q <= (in_func == psl_pkg::FUNC_PUSH) && stack_full;

    func2_q   <= func1_q;
    rgba2_q   <= rgba1_q;
    waddr2_q  <= waddr1_q;
    status2_q <= status1_q;

    func3_q   <= func2_q;
    rgba3_q   <= rgba2_q;
    waddr3_q  <= waddr2_q;
    status3_q <= status2_q;
    hit3_q    <= sel.hit;
    prod3_q   <= ADDR_W'(prod_d);
    off3_q    <= ADDR_W'(sel.dx) + sel_base;

    func4_q   <= func3_q;
    rgba4_q   <= rgba3_q;
    status4_q <= status3_q;
    hit4_q    <= hit3_q;
  end

  // writes and reads share one pipeline slot, so order is kept
  assign ram_we   = v3_q && (func3_q == psl_pkg::FUNC_WRITE);
  assign ram_re   = v3_q && (func3_q == psl_pkg::FUNC_QUERY) && hit3_q;
  assign ram_addr = (func3_q == psl_pkg::FUNC_WRITE) ? waddr3_q : prod3_q + off3_q;

  psl_ram #(
    .WIDTH (psl_pkg::RGB_W),
    .DEPTH (PATCH_PIXELS)
  ) u_patch_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (rgba3_q[psl_pkg::RGB_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_d = '0;
    unique case (func4_q)
      psl_pkg::FUNC_QUERY: begin
        res_d.from_patch = hit4_q;
        if (hit4_q) begin
          {res_d.alpha, res_d.blue, res_d.green, res_d.red} = {psl_pkg::ALPHA_FULL, ram_rdata};
        end else begin
          {res_d.alpha, res_d.blue, res_d.green, res_d.red} = rgba4_q;
        end
      end
      psl_pkg::FUNC_PUSH: begin
        res_d.status = status4_q;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  psl_fifo #(
    .WIDTH (RES_W),
    .DEPTH (psl_pkg::FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v4_q),
    .data_i  (res_d),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (fifo_data)
  );

  assign res_out      = psl_pkg::result_t'(fifo_data);
  assign m_axis_tdata = {res_out.alpha, res_out.blue, res_out.green, res_out.red};
  assign m_axis_tuser = {res_out.status, res_out.from_patch};

endmodule

`default_nettype wire

// ----- hdl/psl_checker.sv -----
// port-level checks on the result stream of the patch stack pixel lookup
`default_nettype none

module psl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_patch_alpha_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:48] == 16'hFFFF)
    else $error("patch result without full alpha");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("refused push reported as patch hit");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0)
    else $error("refused push carries pixel data");

  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result offered during reset");

endmodule

bind patch_stack_pixel_lookup psl_checker u_psl_checker (.*);

`default_nettype wire
